FILE: src/glyph_color_expand_blit_macros.svh
// Assertion helpers for the glyph color expansion blit.
// Both expect clk and rst_n in scope.
`ifndef GLYPH_COLOR_EXPAND_BLIT_MACROS_SVH
`define GLYPH_COLOR_EXPAND_BLIT_MACROS_SVH

`define GCX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define GCX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/gcx_pkg.sv
package gcx_pkg;

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  localparam logic [2:0] REG_DEPTH_MODE     = 3'd0;
  localparam logic [2:0] REG_FG_COLOR       = 3'd1;
  localparam logic [2:0] REG_MSB_FIRST      = 3'd2;
  localparam logic [2:0] REG_CELL_WIDTH     = 3'd3;
  localparam logic [2:0] REG_CELL_HEIGHT    = 3'd4;
  localparam logic [2:0] REG_DEST_ROW_BYTES = 3'd5;

  localparam logic [2:0] MODE_2BPP  = 3'd0;
  localparam logic [2:0] MODE_4BPP  = 3'd1;
  localparam logic [2:0] MODE_8BPP  = 3'd2;
  localparam logic [2:0] MODE_16BPP = 3'd3;
  localparam logic [2:0] MODE_24BPP = 3'd4;
  localparam logic [2:0] MODE_32BPP = 3'd5;

  localparam int MAX_PIXEL_BITS   = 32;
  localparam int ITEM_QUEUE_DEPTH = 2;
  localparam int OFIFO_DEPTH      = 4;
  localparam int OFIFO_PW         = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CW         = $clog2(OFIFO_DEPTH + 1);

  typedef struct packed {
    logic [2:0]  depth_mode;
    logic [31:0] fg_color;
    logic        msb_first;
    logic [15:0] cell_width;
    logic [15:0] cell_height;
    logic [15:0] dest_row_bytes;
  } gcx_cfg_t;

  typedef struct packed {
    logic        command;
    logic [7:0]  bitmap_byte;
    logic [7:0]  clip_width;
    logic [7:0]  clip_height;
    logic [5:0]  row_bytes;
    logic [8:0]  advance_width;
    logic [31:0] base_address;
  } gcx_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [23:0] write_address;
    logic [31:0] write_data;
    logic [31:0] write_mask;
    logic [8:0]  advance_width;
    logic        last;
  } gcx_result_t;

  typedef struct packed {
    logic                busy;
    logic                pend_valid;
    logic [OFIFO_CW-1:0] ofifo_count;
  } gcx_back_status_t;

  function automatic logic [5:0] depth_bits(input logic [2:0] mode);
    unique case (mode)
      MODE_2BPP:  return 6'd2;
      MODE_4BPP:  return 6'd4;
      MODE_8BPP:  return 6'd8;
      MODE_16BPP: return 6'd16;
      MODE_24BPP: return 6'd24;
      default:    return 6'd32;
    endcase
  endfunction

  function automatic logic [2:0] pixel_bytes(input logic [2:0] mode);
    unique case (mode) inside
      MODE_2BPP, MODE_4BPP, MODE_8BPP: return 3'd1;
      MODE_16BPP:                      return 3'd2;
      MODE_24BPP:                      return 3'd3;
      default:                         return 3'd4;
    endcase
  endfunction

  function automatic logic [31:0] pixel_mask(input logic [2:0] mode);
    unique case (mode) inside
      MODE_2BPP, MODE_4BPP, MODE_8BPP: return 32'h0000_00ff;
      MODE_16BPP:                      return 32'h0000_ffff;
      MODE_24BPP:                      return 32'h00ff_ffff;
      default:                         return 32'hffff_ffff;
    endcase
  endfunction

endpackage

FILE: src/gcx_channels.sv
interface gcx_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] bitmap_byte;
  logic [7:0] glyph_width;
  logic [7:0] glyph_height;
  logic [7:0] glyph_x_offset;
  logic [7:0] glyph_y_offset;
  logic [5:0] bitmap_row_bytes;

  modport source(output valid, command, bitmap_byte, glyph_width, glyph_height,
                 glyph_x_offset, glyph_y_offset, bitmap_row_bytes, input ready);
  modport sink(input valid, command, bitmap_byte, glyph_width, glyph_height,
               glyph_x_offset, glyph_y_offset, bitmap_row_bytes, output ready);
endinterface

interface gcx_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [23:0] write_address;
  logic [31:0] write_data;
  logic [31:0] write_mask;
  logic [8:0]  advance_width;
  logic        last;

  modport source(output valid, result_kind, write_address, write_data, write_mask,
                 advance_width, last, input ready);
  modport sink(input valid, result_kind, write_address, write_data, write_mask,
               advance_width, last, output ready);
endinterface

interface gcx_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: src/gcx_queue.sv
module gcx_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  gcx_pkg::gcx_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output gcx_pkg::gcx_item_t  head
);
  import gcx_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  gcx_item_t     mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (!push && pop) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: src/gcx_front.sv
module gcx_front (
  input  gcx_pkg::gcx_cfg_t   cfg,
  gcx_in_if.sink              in_ch,
  input  logic                q_full,
  output logic                q_push,
  output gcx_pkg::gcx_item_t  q_item
);
  import gcx_pkg::*;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // Clip the glyph to the cell and place its first row.
  always_comb begin
    logic [16:0] rem_w;
    logic [16:0] rem_h;
    logic [15:0] rem_w_c;
    logic [15:0] rem_h_c;
    logic [9:0]  xbytes;
    logic [23:0] row_off;
    logic [32:0] base_sum;
    logic [7:0]  xo;

    xo      = in_ch.glyph_x_offset;
    rem_w   = {1'b0, cfg.cell_width} - {9'b0, xo};
    rem_h   = {1'b0, cfg.cell_height} - {9'b0, in_ch.glyph_y_offset};
    rem_w_c = rem_w[16] ? '0 : rem_w[15:0];
    rem_h_c = rem_h[16] ? '0 : rem_h[15:0];

    unique case (cfg.depth_mode)
      MODE_2BPP:  xbytes = 10'(xo >> 2);
      MODE_4BPP:  xbytes = 10'(xo >> 1);
      MODE_8BPP:  xbytes = 10'(xo);
      MODE_16BPP: xbytes = {1'b0, xo, 1'b0};
      MODE_24BPP: xbytes = {1'b0, xo, 1'b0} + {2'b0, xo};
      default:    xbytes = {xo, 2'b0};
    endcase

    row_off  = 24'(in_ch.glyph_y_offset) * 24'(cfg.dest_row_bytes);
    base_sum = 33'(row_off) + 33'(xbytes);

    q_item.command       = in_ch.command;
    q_item.bitmap_byte   = in_ch.bitmap_byte;
    q_item.clip_width    = (rem_w_c < {8'b0, in_ch.glyph_width}) ? rem_w_c[7:0]
                                                                  : in_ch.glyph_width;
    q_item.clip_height   = (rem_h_c < {8'b0, in_ch.glyph_height}) ? rem_h_c[7:0]
                                                                   : in_ch.glyph_height;
    q_item.row_bytes     = (in_ch.bitmap_row_bytes == '0) ? 6'd1 : in_ch.bitmap_row_bytes;
    q_item.advance_width = 9'(in_ch.glyph_width) + 9'(xo);
    q_item.base_address  = base_sum[31:0];
  end

endmodule

FILE: src/gcx_back.sv
module gcx_back #(
  parameter int ADDRESS_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gcx_pkg::gcx_cfg_t         cfg,
  input  logic                      head_valid,
  input  gcx_pkg::gcx_item_t        head,
  output logic                      pop,
  gcx_out_if.source                 out_ch,
  output gcx_pkg::gcx_back_status_t status
);
  import gcx_pkg::*;

  localparam int AW = ADDRESS_BITS;

  localparam logic ST_BITS   = 1'b0;
  localparam logic ST_ROWEND = 1'b1;

  logic          st_r, st_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [7:0]    row_r, row_nxt;
  logic [7:0]    col_r, col_nxt;
  logic [5:0]    bir_r, bir_nxt;
  logic [7:0]    cw_r, cw_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic [5:0]    held_r, held_nxt;
  logic [AW-1:0] rba_r, rba_nxt;
  logic [AW-1:0] ua_r, ua_nxt;
  logic [7:0]    pdata_r, pdata_nxt;
  logic [7:0]    pmask_r, pmask_nxt;
  logic [3:0]    pbc_r, pbc_nxt;

  logic          pend_valid_r, pend_valid_nxt;
  gcx_result_t   pend_r, pend_nxt;

  gcx_result_t         ofifo_r [OFIFO_DEPTH];
  logic [OFIFO_PW-1:0] wr_ptr_r;
  logic [OFIFO_PW-1:0] rd_ptr_r;
  logic [OFIFO_CW-1:0] cnt_r;

  logic          n_valid;
  gcx_result_t   n_res;
  logic          fin;
  logic          go;
  logic          pop_out;
  logic [1:0]    npush;
  gcx_result_t   e0, e1;
  gcx_result_t   ohead;

  function automatic logic [23:0] addr24(input logic [AW-1:0] a);
    logic [31:0] w;
    w = 32'(a);
    return w[23:0];
  endfunction

  function automatic gcx_result_t mk_write(input logic [AW-1:0] a,
                                           input logic [31:0] d,
                                           input logic [31:0] m);
    gcx_result_t r;
    r.result_kind   = KIND_WRITE;
    r.write_address = addr24(a);
    r.write_data    = d;
    r.write_mask    = m;
    r.advance_width = '0;
    r.last          = 1'b0;
    return r;
  endfunction

  // One pixel per step; row end with a partial packed byte takes one more step.
  always_comb begin
    logic          sub;
    logic          first;
    logic          set;
    logic          px_fits;
    logic          done;
    logic [5:0]    bits6;
    logic [3:0]    bits4;
    logic [3:0]    shift;
    logic [31:0]   pm32;
    logic [7:0]    pd;
    logic [7:0]    pmk;
    logic [7:0]    pmb;
    logic [7:0]    pbase;
    logic [7:0]    mp;
    logic [3:0]    pbc;
    logic [4:0]    pbc_sum;
    logic [AW-1:0] ua;
    logic [AW-1:0] rba_step;
    logic [7:0]    col_inc;
    logic [5:0]    bir_inc;

    st_nxt    = st_r;
    bit_nxt   = bit_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    bir_nxt   = bir_r;
    cw_nxt    = cw_r;
    ch_nxt    = ch_r;
    held_nxt  = held_r;
    rba_nxt   = rba_r;
    ua_nxt    = ua_r;
    pdata_nxt = pdata_r;
    pmask_nxt = pmask_r;
    pbc_nxt   = pbc_r;
    n_valid   = 1'b0;
    n_res     = '0;
    fin       = 1'b0;

    bits6    = depth_bits(cfg.depth_mode);
    bits4    = bits6[3:0];
    sub      = (cfg.depth_mode == MODE_2BPP) || (cfg.depth_mode == MODE_4BPP);
    px_fits  = (32'(bits6) <= 32'(MAX_PIXEL_BITS));
    pm32     = pixel_mask(cfg.depth_mode);
    first    = (st_r == ST_BITS) && (bit_r == 3'd7);
    set      = head.bitmap_byte[bit_r];
    pd       = pdata_r;
    pmk      = pmask_r;
    pbc      = pbc_r;
    ua       = ua_r;
    col_inc  = col_r + 8'd1;
    bir_inc  = bir_r + 6'd1;
    rba_step = rba_r + AW'(cfg.dest_row_bytes);
    pbase    = (bits4 == 4'd2) ? 8'h03 : 8'h0f;
    mp       = (bits4 == 4'd2) ? {4{cfg.fg_color[1:0]}} : {2{cfg.fg_color[3:0]}};
    shift    = '0;
    pmb      = '0;
    pbc_sum  = '0;
    done     = 1'b0;

    unique case (st_r)
      ST_BITS: begin
        if (head.command == CMD_BEGIN) begin
          cw_nxt    = head.clip_width;
          ch_nxt    = head.clip_height;
          held_nxt  = head.row_bytes;
          rba_nxt   = head.base_address[AW-1:0];
          ua_nxt    = head.base_address[AW-1:0];
          row_nxt   = '0;
          col_nxt   = '0;
          bir_nxt   = '0;
          pdata_nxt = '0;
          pmask_nxt = '0;
          pbc_nxt   = '0;
          n_valid   = 1'b1;
          n_res.result_kind   = KIND_REPORT;
          n_res.advance_width = head.advance_width;
          fin       = 1'b1;
        end else if (row_r >= ch_r) begin
          fin = 1'b1;
        end else if (col_r >= cw_r) begin
          fin = 1'b1;
          if (bir_inc >= held_r) begin
            if (pbc_r != '0 && pmask_r != '0) begin
              n_valid = 1'b1;
              n_res   = mk_write(ua_r, 32'(pdata_r), 32'(pmask_r));
            end
            pdata_nxt = '0;
            pmask_nxt = '0;
            pbc_nxt   = '0;
            row_nxt   = row_r + 8'd1;
            col_nxt   = '0;
            bir_nxt   = '0;
            rba_nxt   = rba_step;
            ua_nxt    = rba_step;
          end else begin
            bir_nxt = bir_inc;
          end
        end else begin
          if (!sub) begin
            if (first) begin
              pd  = '0;
              pmk = '0;
              pbc = '0;
            end
            if (set && px_fits) begin
              n_valid = 1'b1;
              n_res   = mk_write(ua, cfg.fg_color & pm32, pm32);
            end
            ua = ua + AW'(pixel_bytes(cfg.depth_mode));
          end else begin
            pbc_sum = {1'b0, pbc} + {1'b0, bits4};
            if (pbc_sum > 5'd8) begin
              if (pmk != '0) begin
                n_valid = 1'b1;
                n_res   = mk_write(ua, 32'(pd), 32'(pmk));
              end
              ua  = ua + AW'(1);
              pd  = '0;
              pmk = '0;
              pbc = '0;
            end
            shift = cfg.msb_first ? (4'd8 - bits4 - pbc) : pbc;
            pmb   = pbase << shift;
            if (set) begin
              pd  = (pd & ~pmb) | (mp & pmb);
              pmk = pmk | pmb;
            end
            pbc = pbc + bits4;
            if (pbc >= 4'd8) begin
              if (pmk != '0) begin
                n_valid = 1'b1;
                n_res   = mk_write(ua, 32'(pd), 32'(pmk));
              end
              ua  = ua + AW'(1);
              pd  = '0;
              pmk = '0;
              pbc = '0;
            end
          end
          pdata_nxt = pd;
          pmask_nxt = pmk;
          pbc_nxt   = pbc;
          ua_nxt    = ua;
          col_nxt   = col_inc;
          done      = (bit_r == 3'd0) || (col_inc >= cw_r);
          if (!done) begin
            bit_nxt = bit_r - 3'd1;
          end else if (bir_inc >= held_r) begin
            if (pbc != '0) begin
              st_nxt  = ST_ROWEND;
              bit_nxt = 3'd7;
            end else begin
              row_nxt = row_r + 8'd1;
              col_nxt = '0;
              bir_nxt = '0;
              rba_nxt = rba_step;
              ua_nxt  = rba_step;
              bit_nxt = 3'd7;
              fin     = 1'b1;
            end
          end else begin
            bir_nxt = bir_inc;
            bit_nxt = 3'd7;
            fin     = 1'b1;
          end
        end
      end
      ST_ROWEND: begin
        if (pmask_r != '0) begin
          n_valid = 1'b1;
          n_res   = mk_write(ua_r, 32'(pdata_r), 32'(pmask_r));
        end
        pdata_nxt = '0;
        pmask_nxt = '0;
        pbc_nxt   = '0;
        row_nxt   = row_r + 8'd1;
        col_nxt   = '0;
        bir_nxt   = '0;
        rba_nxt   = rba_step;
        ua_nxt    = rba_step;
        st_nxt    = ST_BITS;
        bit_nxt   = 3'd7;
        fin       = 1'b1;
      end
    endcase
  end

  // Hold the newest write of an item until it is known whether it is the final one.
  always_comb begin
    logic [1:0]        need;
    logic [OFIFO_CW:0] free;

    e0             = pend_r;
    e1             = n_res;
    need           = '0;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;

    if (fin) begin
      need = {1'b0, pend_valid_r} + {1'b0, n_valid};
      if (pend_valid_r) begin
        e0.last = !n_valid;
        e1.last = 1'b1;
      end else begin
        e0      = n_res;
        e0.last = 1'b1;
      end
      pend_valid_nxt = 1'b0;
    end else if (n_valid) begin
      need           = {1'b0, pend_valid_r};
      e0.last        = 1'b0;
      pend_nxt       = n_res;
      pend_valid_nxt = 1'b1;
    end

    free  = (OFIFO_CW + 1)'(OFIFO_DEPTH) - {1'b0, cnt_r} + (OFIFO_CW + 1)'(pop_out);
    go    = head_valid && ((OFIFO_CW + 1)'(need) <= free);
    npush = go ? need : 2'd0;
  end

  assign pop     = go && fin;
  assign ohead   = ofifo_r[rd_ptr_r];
  assign pop_out = out_ch.valid && out_ch.ready;

  assign out_ch.valid         = (cnt_r != '0);
  assign out_ch.result_kind   = ohead.result_kind;
  assign out_ch.write_address = ohead.write_address;
  assign out_ch.write_data    = ohead.write_data;
  assign out_ch.write_mask    = ohead.write_mask;
  assign out_ch.advance_width = ohead.advance_width;
  assign out_ch.last          = ohead.last;

  assign status.busy        = (st_r == ST_ROWEND) || (bit_r != 3'd7);
  assign status.pend_valid  = pend_valid_r;
  assign status.ofifo_count = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_BITS;
      bit_r        <= 3'd7;
      row_r        <= '0;
      col_r        <= '0;
      bir_r        <= '0;
      cw_r         <= '0;
      ch_r         <= '0;
      held_r       <= 6'd1;
      rba_r        <= '0;
      ua_r         <= '0;
      pdata_r      <= '0;
      pmask_r      <= '0;
      pbc_r        <= '0;
      pend_valid_r <= 1'b0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      cnt_r        <= '0;
    end else begin
      if (go) begin
        st_r         <= st_nxt;
        bit_r        <= bit_nxt;
        row_r        <= row_nxt;
        col_r        <= col_nxt;
        bir_r        <= bir_nxt;
        cw_r         <= cw_nxt;
        ch_r         <= ch_nxt;
        held_r       <= held_nxt;
        rba_r        <= rba_nxt;
        ua_r         <= ua_nxt;
        pdata_r      <= pdata_nxt;
        pmask_r      <= pmask_nxt;
        pbc_r        <= pbc_nxt;
        pend_valid_r <= pend_valid_nxt;
      end
      wr_ptr_r <= wr_ptr_r + OFIFO_PW'(npush);
      rd_ptr_r <= rd_ptr_r + OFIFO_PW'(pop_out);
      cnt_r    <= cnt_r + OFIFO_CW'(npush) - OFIFO_CW'(pop_out);
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      pend_r <= pend_nxt;
    end
    if (npush != 2'd0) begin
      ofifo_r[wr_ptr_r] <= e0;
    end
    if (npush == 2'd2) begin
      ofifo_r[wr_ptr_r + OFIFO_PW'(1)] <= e1;
    end
  end

endmodule

FILE: src/glyph_color_expand_blit.sv
// Path: an advance report goes through the item queue and the result buffer; a write
//   is held until the next write or its item's end before it enters the result buffer.
// Throughput: one begin item per cycle while the result buffer has room; each bitmap
//   byte takes one sequencer step per clipped pixel, plus one at a partial-byte row end.
// Reset: rst_n is synchronous, active low; it restores the registers to their defaults
//   and clears the glyph state, the item queue and the result buffer.
`include "glyph_color_expand_blit_macros.svh"

module glyph_color_expand_blit #(
  parameter int ADDRESS_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  gcx_cfg_if.sink   cfg_ch,
  gcx_in_if.sink    in_ch,
  gcx_out_if.source out_ch
);
  import gcx_pkg::*;

  gcx_cfg_t         cfg_r;
  logic             q_full;
  logic             q_push;
  gcx_item_t        q_item;
  logic             q_pop;
  logic             q_head_valid;
  gcx_item_t        q_head;
  gcx_back_status_t back_st;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_mode     <= MODE_8BPP;
      cfg_r.fg_color       <= '0;
      cfg_r.msb_first      <= 1'b0;
      cfg_r.cell_width     <= '0;
      cfg_r.cell_height    <= '0;
      cfg_r.dest_row_bytes <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_DEPTH_MODE:     cfg_r.depth_mode     <= cfg_ch.data[2:0];
        REG_FG_COLOR:       cfg_r.fg_color       <= cfg_ch.data;
        REG_MSB_FIRST:      cfg_r.msb_first      <= cfg_ch.data[0];
        REG_CELL_WIDTH:     cfg_r.cell_width     <= cfg_ch.data[15:0];
        REG_CELL_HEIGHT:    cfg_r.cell_height    <= cfg_ch.data[15:0];
        REG_DEST_ROW_BYTES: cfg_r.dest_row_bytes <= cfg_ch.data[15:0];
        default: begin
        end
      endcase
    end
  end

  gcx_front u_front (
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_item)
  );

  gcx_queue #(
    .DEPTH (ITEM_QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  gcx_back #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch),
    .status     (back_st)
  );

  `GCX_ASSERT_IMP(a_pend_idle, !back_st.busy, !back_st.pend_valid, "held write outside an item")
  `GCX_ASSERT_IMP(a_more_follow, out_ch.valid && out_ch.ready && !out_ch.last, (back_st.ofifo_count > OFIFO_CW'(1)) || back_st.pend_valid || back_st.busy, "non-final write with nothing after it")
  `GCX_ASSERT_IMP(a_report_form, out_ch.valid && out_ch.result_kind == KIND_REPORT, out_ch.last && out_ch.write_mask == 32'd0, "malformed advance report")
  `GCX_ASSERT_NXT(a_ofifo_hold, back_st.ofifo_count == OFIFO_CW'(OFIFO_DEPTH) && !out_ch.ready, back_st.ofifo_count == OFIFO_CW'(OFIFO_DEPTH), "result buffer overrun")

endmodule
